// ===== rtl/ctlv_pkg.sv =====
`default_nettype none
package ctlv_pkg;

  localparam int MotorEntries = 39;
  localparam int CtrlEntries  = 32;
  localparam int IdxW         = 6;
  localparam int RawW         = 16;
  localparam int TempW        = 11;
  localparam int LvlW         = 16;
  localparam int LimW         = 8;
  localparam int CfgIdxW      = 8;
  localparam int DenW         = 16;
  localparam int DivW         = 24;
  localparam int NumW         = 30;
  localparam int ProdW        = 22;

  localparam logic [7:0] CodeMotor = 8'h49;
  localparam logic [7:0] CodeCtrl  = 8'h4a;

  localparam logic [CfgIdxW-1:0] RegMotorLimit = 8'd0;
  localparam logic [CfgIdxW-1:0] RegCtrlLimit  = 8'd1;

  localparam logic [LimW-1:0] MotorLimitReset = 8'd45;
  localparam logic [LimW-1:0] CtrlLimitReset  = 8'd70;

  localparam logic signed [TempW-1:0] LevelScale = 11'sd1000;
  localparam logic signed [LvlW+8:0]  LvlMax     = 25'sd32767;
  localparam logic signed [LvlW+8:0]  LvlMin     = -25'sd32768;

  localparam logic signed [LvlW-1:0] Band5 = 16'sd1000;
  localparam logic signed [LvlW-1:0] Band4 = 16'sd900;
  localparam logic signed [LvlW-1:0] Band3 = 16'sd800;
  localparam logic signed [LvlW-1:0] Band2 = 16'sd700;
  localparam logic signed [LvlW-1:0] Band1 = 16'sd600;

  localparam logic [IdxW-1:0] MotorLast = IdxW'(MotorEntries - 1);
  localparam logic [IdxW-1:0] CtrlLast  = IdxW'(CtrlEntries - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEARCH, ST_MUL, ST_SUM, ST_DIV_T_GO, ST_DIV_T,
    ST_SCALE, ST_DIV_L_GO, ST_DIV_L, ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic seg;
    logic clamp;
    logic mul;
    logic sum;
    logic div_start;
    logic div_sel_lvl;
    logic fin_t;
    logic scale;
    logic fin_l;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic code_ok;
    logic hit;
    logic last;
    logic div_done;
    logic div_busy;
    logic out_busy;
  } status_t;

  function automatic logic [RawW-1:0] motor_raw(input logic [IdxW-1:0] i);
    logic [RawW-1:0] r;
    case (i)
      6'd0: r = 16'd7414;   6'd1: r = 16'd7687;   6'd2: r = 16'd7962;
      6'd3: r = 16'd8240;   6'd4: r = 16'd8520;   6'd5: r = 16'd8802;
      6'd6: r = 16'd9085;   6'd7: r = 16'd9369;   6'd8: r = 16'd9654;
      6'd9: r = 16'd9939;   6'd10: r = 16'd10225; 6'd11: r = 16'd10510;
      6'd12: r = 16'd10795; 6'd13: r = 16'd11080; 6'd14: r = 16'd11364;
      6'd15: r = 16'd11646; 6'd16: r = 16'd11927; 6'd17: r = 16'd12207;
      6'd18: r = 16'd12485; 6'd19: r = 16'd12762; 6'd20: r = 16'd13036;
      6'd21: r = 16'd13308; 6'd22: r = 16'd13578; 6'd23: r = 16'd13846;
      6'd24: r = 16'd14111; 6'd25: r = 16'd14373; 6'd26: r = 16'd14633;
      6'd27: r = 16'd14890; 6'd28: r = 16'd15144; 6'd29: r = 16'd15391;
      6'd30: r = 16'd15632; 6'd31: r = 16'd15852; 6'd32: r = 16'd16061;
      6'd33: r = 16'd16251; 6'd34: r = 16'd16421; 6'd35: r = 16'd16569;
      6'd36: r = 16'd16692; 6'd37: r = 16'd16789; 6'd38: r = 16'd16857;
      default: r = 16'd16857;
    endcase
    return r;
  endfunction

  function automatic logic signed [TempW-1:0] motor_deg(input logic [IdxW-1:0] i);
    logic signed [TempW-1:0] d;
    if (i < MotorLast) begin
      d = TempW'(signed'(5 * int'(i)) - 35);
    end else begin
      d = 11'sd155;
    end
    return d;
  endfunction

  function automatic logic [RawW-1:0] ctrl_raw(input logic [IdxW-1:0] i);
    logic [RawW-1:0] r;
    case (i)
      6'd0: r = 16'd28480;  6'd1: r = 16'd28179;  6'd2: r = 16'd27851;
      6'd3: r = 16'd27497;  6'd4: r = 16'd27114;  6'd5: r = 16'd26702;
      6'd6: r = 16'd26261;  6'd7: r = 16'd25792;  6'd8: r = 16'd25296;
      6'd9: r = 16'd24775;  6'd10: r = 16'd24232; 6'd11: r = 16'd23671;
      6'd12: r = 16'd23097; 6'd13: r = 16'd22515; 6'd14: r = 16'd21933;
      6'd15: r = 16'd21357; 6'd16: r = 16'd20793; 6'd17: r = 16'd20250;
      6'd18: r = 16'd19733; 6'd19: r = 16'd19247; 6'd20: r = 16'd18797;
      6'd21: r = 16'd18387; 6'd22: r = 16'd18017; 6'd23: r = 16'd17688;
      6'd24: r = 16'd17400; 6'd25: r = 16'd17151; 6'd26: r = 16'd16938;
      6'd27: r = 16'd16757; 6'd28: r = 16'd16609; 6'd29: r = 16'd16487;
      6'd30: r = 16'd16387; 6'd31: r = 16'd16308;
      default: r = 16'd16308;
    endcase
    return r;
  endfunction

  function automatic logic signed [TempW-1:0] ctrl_deg(input logic [IdxW-1:0] i);
    logic signed [TempW-1:0] d;
    if (i < CtrlLast) begin
      d = TempW'(125 - signed'(5 * int'(i)));
    end else begin
      d = -11'sd30;
    end
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/ctlv_if.sv =====
`default_nettype none
interface ctlv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_code;
  logic [7:0] reading_low;
  logic [7:0] reading_high;
  modport source (output valid, message_code, reading_low, reading_high, input ready);
  modport sink (input valid, message_code, reading_low, reading_high, output ready);
endinterface

interface ctlv_out_if;
  logic               valid;
  logic               ready;
  logic               sensor_kind;
  logic signed [10:0] temperature_c;
  logic signed [15:0] motor_level;
  logic signed [15:0] controller_level;
  logic signed [15:0] hottest_level;
  logic [2:0]         cooling_band;
  modport source (output valid, sensor_kind, temperature_c, motor_level, controller_level,
                  hottest_level, cooling_band, input ready);
  modport sink (input valid, sensor_kind, temperature_c, motor_level, controller_level,
                hottest_level, cooling_band, output ready);
endinterface

interface ctlv_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ctlv_div.sv =====
`default_nettype none
module ctlv_div
  import ctlv_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DivW-1:0]   dividend_i,
  input  logic [DenW-1:0]   divisor_i,
  output logic              busy_o,
  output logic              done_o,
  output logic [DivW-1:0]   quot_o
);

  localparam int CntW = $clog2(DivW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [DenW-1:0] rem_q, rem_d, div_q, div_d;
  logic [DivW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_sh;
  logic            fits;

  always_comb begin
    rem_sh = {rem_q, quo_q[DivW-1]};
    fits   = rem_sh >= {1'b0, div_q};
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i) begin
      cnt_d  = '0;
      busy_d = 1'b1;
      rem_d  = '0;
      div_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? DenW'(rem_sh - {1'b0, div_q}) : rem_sh[DenW-1:0];
      quo_d = {quo_q[DivW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

// ===== rtl/ctlv_dp.sv =====
`default_nettype none
module ctlv_dp
  import ctlv_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output status_t                 status_o,
  input  logic                    cfg_valid_i,
  input  logic [CfgIdxW-1:0]      cfg_index_i,
  input  logic [LimW-1:0]         cfg_data_i,
  input  logic [7:0]              message_code_i,
  input  logic [7:0]              reading_low_i,
  input  logic [7:0]              reading_high_i,
  input  logic                    out_ready_i,
  output logic                    out_valid_o,
  output logic                    sensor_kind_o,
  output logic signed [TempW-1:0] temperature_c_o,
  output logic signed [LvlW-1:0]  motor_level_o,
  output logic signed [LvlW-1:0]  controller_level_o,
  output logic signed [LvlW-1:0]  hottest_level_o,
  output logic [2:0]              cooling_band_o
);

  logic [LimW-1:0]         mlim_q, clim_q;
  logic                    kind_q;
  logic [RawW-1:0]         r_q;
  logic [IdxW-1:0]         idx_q, idx_prev;
  logic [RawW-1:0]         va_q, raw_cur;
  logic signed [TempW-1:0] ta_q, tb_q, temp_q;
  logic signed [DenW:0]    den_q;
  logic signed [NumW-1:0]  p1_q, num_q;
  logic signed [DenW:0]    diff_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [LvlW-1:0]  lvl_q, mstore_q, cstore_q, m_n, c_n, hot_n;
  logic                    neg_q;
  logic                    out_valid_q;
  logic                    out_kind_q;
  logic signed [TempW-1:0] out_temp_q;
  logic signed [LvlW-1:0]  out_m_q, out_c_q, out_hot_q;
  logic [2:0]              out_band_q, band_n;
  logic signed [NumW-1:0]  num_abs;
  logic signed [ProdW-1:0] prod_abs;
  logic [DivW-1:0]         dividend;
  logic [DenW-1:0]         divisor;
  logic [LimW-1:0]         lim;
  logic                    div_busy, div_done;
  logic [DivW-1:0]         quot;
  logic signed [LvlW+8:0]  lvl_full;
  logic signed [TempW-1:0] dt;

  assign idx_prev = idx_q - 1'b1;
  assign raw_cur  = kind_q ? ctrl_raw(idx_q) : motor_raw(idx_q);

  always_comb begin
    status_o.code_ok  = (message_code_i == CodeMotor) || (message_code_i == CodeCtrl);
    status_o.hit      = kind_q ? (r_q >= raw_cur) : (r_q <= raw_cur);
    status_o.last     = idx_q == (kind_q ? CtrlLast : MotorLast);
    status_o.div_done = div_done;
    status_o.div_busy = div_busy;
    status_o.out_busy = out_valid_q && !out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mlim_q <= MotorLimitReset;
      clim_q <= CtrlLimitReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegMotorLimit) begin
        mlim_q <= cfg_data_i;
      end else if (cfg_index_i == RegCtrlLimit) begin
        clim_q <= cfg_data_i;
      end
    end
  end

  assign num_abs  = num_q[NumW-1] ? -num_q : num_q;
  assign prod_abs = prod_q[ProdW-1] ? -prod_q : prod_q;
  assign lim      = kind_q ? clim_q : mlim_q;
  assign dividend = cmd_i.div_sel_lvl ? DivW'(prod_abs) : num_abs[DivW-1:0];
  assign divisor  = cmd_i.div_sel_lvl ? DenW'((lim == '0) ? LimW'(1) : lim) : den_q[DenW-1:0];
  assign dt       = tb_q - ta_q;

  ctlv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  assign lvl_full = neg_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= message_code_i == CodeCtrl;
      r_q    <= {reading_high_i, reading_low_i};
      idx_q  <= IdxW'(1);
    end
    if (cmd_i.step) begin
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.seg) begin
      if (kind_q) begin
        va_q  <= ctrl_raw(idx_q);
        ta_q  <= ctrl_deg(idx_q);
        tb_q  <= ctrl_deg(idx_prev);
        den_q <= $signed({1'b0, ctrl_raw(idx_prev)}) - $signed({1'b0, ctrl_raw(idx_q)});
      end else begin
        va_q  <= motor_raw(idx_prev);
        ta_q  <= motor_deg(idx_prev);
        tb_q  <= motor_deg(idx_q);
        den_q <= $signed({1'b0, motor_raw(idx_q)}) - $signed({1'b0, motor_raw(idx_prev)});
      end
    end
    if (cmd_i.clamp) begin
      temp_q <= kind_q ? ctrl_deg(CtrlLast) : motor_deg(MotorLast);
    end
    if (cmd_i.mul) begin
      p1_q   <= NumW'(ta_q * den_q);
      diff_q <= $signed({1'b0, r_q}) - $signed({1'b0, va_q});
    end
    if (cmd_i.sum) begin
      num_q <= p1_q + NumW'(diff_q * dt);
    end
    if (cmd_i.div_start) begin
      neg_q <= cmd_i.div_sel_lvl ? prod_q[ProdW-1] : num_q[NumW-1];
    end
    if (cmd_i.fin_t) begin
      temp_q <= (den_q == '0) ? ta_q : TempW'(lvl_full);
    end
    if (cmd_i.scale) begin
      prod_q <= ProdW'(temp_q) * ProdW'(LevelScale);
    end
    if (cmd_i.fin_l) begin
      if (lvl_full > LvlMax) begin
        lvl_q <= LvlW'(LvlMax);
      end else if (lvl_full < LvlMin) begin
        lvl_q <= LvlW'(LvlMin);
      end else begin
        lvl_q <= LvlW'(lvl_full);
      end
    end
  end

  always_comb begin
    m_n   = kind_q ? mstore_q : lvl_q;
    c_n   = kind_q ? lvl_q : cstore_q;
    hot_n = (m_n > c_n) ? m_n : c_n;
    if (hot_n >= Band5) begin
      band_n = 3'd5;
    end else if (hot_n >= Band4) begin
      band_n = 3'd4;
    end else if (hot_n >= Band3) begin
      band_n = 3'd3;
    end else if (hot_n >= Band2) begin
      band_n = 3'd2;
    end else if (hot_n >= Band1) begin
      band_n = 3'd1;
    end else begin
      band_n = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mstore_q    <= '0;
      cstore_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        mstore_q    <= m_n;
        cstore_q    <= c_n;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_q <= kind_q;
      out_temp_q <= temp_q;
      out_m_q    <= m_n;
      out_c_q    <= c_n;
      out_hot_q  <= hot_n;
      out_band_q <= band_n;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign sensor_kind_o      = out_kind_q;
  assign temperature_c_o    = out_temp_q;
  assign motor_level_o      = out_m_q;
  assign controller_level_o = out_c_q;
  assign hottest_level_o    = out_hot_q;
  assign cooling_band_o     = out_band_q;

endmodule
`default_nettype wire

// ===== rtl/ctlv_ctrl.sv =====
`default_nettype none
module ctlv_ctrl
  import ctlv_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i && status_i.code_ok) state_d = ST_SEARCH;
      ST_SEARCH: begin
        if (status_i.hit) begin
          state_d = ST_MUL;
        end else if (status_i.last) begin
          state_d = ST_SCALE;
        end
      end
      ST_MUL:      state_d = ST_SUM;
      ST_SUM:      state_d = ST_DIV_T_GO;
      ST_DIV_T_GO: state_d = ST_DIV_T;
      ST_DIV_T:    if (status_i.div_done) state_d = ST_SCALE;
      ST_SCALE:    state_d = ST_DIV_L_GO;
      ST_DIV_L_GO: state_d = ST_DIV_L;
      ST_DIV_L:    if (status_i.div_done) state_d = ST_EMIT;
      ST_EMIT:     if (!status_i.out_busy) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i && status_i.code_ok;
      end
      ST_SEARCH: begin
        cmd_o.seg   = status_i.hit;
        cmd_o.clamp = !status_i.hit && status_i.last;
        cmd_o.step  = !status_i.hit && !status_i.last;
      end
      ST_MUL:      cmd_o.mul = 1'b1;
      ST_SUM:      cmd_o.sum = 1'b1;
      ST_DIV_T_GO: cmd_o.div_start = 1'b1;
      ST_DIV_T:    cmd_o.fin_t = status_i.div_done;
      ST_SCALE:    cmd_o.scale = 1'b1;
      ST_DIV_L_GO: begin
        cmd_o.div_start   = 1'b1;
        cmd_o.div_sel_lvl = 1'b1;
      end
      ST_DIV_L:    cmd_o.fin_l = status_i.div_done;
      ST_EMIT:     cmd_o.emit = !status_i.out_busy;
      default:     cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/can_temperature_lut_level.sv =====
// Temperature level block.
// in_ch carries one temperature message per beat: a code byte and a 16-bit
// little-endian raw reading. Code 0x49 is a motor reading, 0x4a a controller
// reading; other codes are taken and dropped without a result.
// out_ch gives one beat per known code: the converted temperature, both stored
// levels, the greater of them and its cooling band.
// cfg_ch writes the two limit registers (index 0 motor, 1 controller); it is
// always ready. Write only while the block is idle.
// Path from input beat to output valid: a table search (one entry per cycle),
// a multiply and a sum, then two divisions on the shared 24-step divider, one
// for the temperature and one for the level, with a scaling step between.
// A reading past the table end skips the first division.
// One message is worked at a time; in_ch.ready is high only between messages,
// so a new message is taken only once the last one has been emitted.
// The result sits in an output register; a stalled receiver holds the finished
// beat while the block takes and works the next message, which then waits
// until the register is free.
// Reset clears both stored levels to 0 and loads limits 45 and 70.
`default_nettype none
module can_temperature_lut_level
  import ctlv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ctlv_cfg_if.sink    cfg_ch,
  ctlv_in_if.sink     in_ch,
  ctlv_out_if.source  out_ch
);

  cmd_t    cmd;
  status_t st;

  assign cfg_ch.ready = 1'b1;

  ctlv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ch.ready),
    .status_i   (st),
    .cmd_o      (cmd)
  );

  ctlv_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (st),
    .cfg_valid_i        (cfg_ch.valid),
    .cfg_index_i        (cfg_ch.index),
    .cfg_data_i         (cfg_ch.data),
    .message_code_i     (in_ch.message_code),
    .reading_low_i      (in_ch.reading_low),
    .reading_high_i     (in_ch.reading_high),
    .out_ready_i        (out_ch.ready),
    .out_valid_o        (out_ch.valid),
    .sensor_kind_o      (out_ch.sensor_kind),
    .temperature_c_o    (out_ch.temperature_c),
    .motor_level_o      (out_ch.motor_level),
    .controller_level_o (out_ch.controller_level),
    .hottest_level_o    (out_ch.hottest_level),
    .cooling_band_o     (out_ch.cooling_band)
  );

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !(out_ch.valid && !out_ch.ready))
    else $error("emit over a waiting beat");

  a_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.ready |-> !st.div_busy)
    else $error("divider busy while idle");

  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> !in_ch.ready)
    else $error("ready right after a taken message");

  a_hottest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> (out_ch.hottest_level == out_ch.motor_level ||
                      out_ch.hottest_level == out_ch.controller_level))
    else $error("hottest level is neither stored level");

endmodule
`default_nettype wire
